// ===== hdl/tzpg_pkg.sv =====
// Package: gesture codes, constants and the event bundle of the passage classifier.
`default_nettype none
package tzpg_pkg;

	localparam int SEQ_LEN = 5;
	localparam int IDX_W = 3;
	localparam logic [15:0] THRESH_RESET = 16'd800;

	typedef enum logic [3:0] {
		G_START     = 4'd0,
		G_IN_RANGE  = 4'd1,
		G_END       = 4'd2,
		G_IN_OUT    = 4'd3,
		G_ENTERS    = 4'd4,
		G_LEAVES    = 4'd5,
		G_TRY_ENTER = 4'd6,
		G_TRY_LEAVE = 4'd7,
		G_TOO_FAST  = 4'd8,
		G_DET_ERR   = 4'd9,
		G_NOT_FULL  = 4'd10,
		G_READ_ERR  = 4'd11
	} gesture_t;

	// events produced by one sample: up to two words
	typedef struct packed {
		logic [1:0]         n;
		gesture_t           g0;
		gesture_t           g1;
		logic signed [15:0] cnt_old;
		logic signed [15:0] cnt_new;
	} evt_t;

endpackage
`default_nettype wire

// ===== hdl/tzpg_if.sv =====
// Interfaces: sample channel and gesture event channel.
`default_nettype none
interface tzpg_sample_if;
	logic        valid;
	logic        ready;
	logic        read_ok;
	logic [15:0] front_dist_mm;
	logic [15:0] back_dist_mm;

	modport source (output valid, read_ok, front_dist_mm, back_dist_mm, input ready);
	modport sink (input valid, read_ok, front_dist_mm, back_dist_mm, output ready);
endinterface

interface tzpg_event_if;
	logic               valid;
	logic               ready;
	logic [3:0]         gesture;
	logic signed [15:0] people_count;
	logic               last_of_run;

	modport source (output valid, gesture, people_count, last_of_run, input ready);
	modport sink (input valid, gesture, people_count, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hdl/tzpg_core.sv =====
// Classifier core: zone status, sequence state, decode and occupancy count.
`default_nettype none
module tzpg_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          read_ok,
	input  wire logic [15:0]   front_dist_mm,
	input  wire logic [15:0]   back_dist_mm,
	input  wire logic [15:0]   threshold_mm,
	output tzpg_pkg::evt_t     evt
);
	import tzpg_pkg::*;

	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [1:0]         last_q, last_d;
	logic [1:0]         seq_q [SEQ_LEN];
	logic [1:0]         seq_d [SEQ_LEN];
	logic signed [15:0] occ_q, occ_d;
	logic [1:0]         now;
	logic [1:0]         n;
	gesture_t           g0, g1, gx;
	logic [3:0]         sum;

	assign now = {front_dist_mm < threshold_mm, back_dist_mm < threshold_mm};

	always_comb begin
		idx_d = idx_q;
		last_d = last_q;
		seq_d = seq_q;
		occ_d = occ_q;
		n = 2'd0;
		g0 = G_START;
		g1 = G_START;
		gx = G_START;
		sum = 4'd0;
		if (!read_ok) begin
			n = 2'd1;
			g0 = G_READ_ERR;
		end else begin
			if (now != last_q) begin
				if (idx_q == 3'd0)
					g0 = G_START;
				else if (idx_q == 3'd3)
					g0 = G_END;
				else
					g0 = G_IN_RANGE;
				n = 2'd1;
				if (idx_q < IDX_W'(SEQ_LEN - 1)) begin
					idx_d = idx_q + 3'd1;
					for (int k = 0; k < SEQ_LEN; k++)
						if (idx_d == IDX_W'(k))
							seq_d[k] = now;
				end
				last_d = now;
				if (idx_d == 3'd4 && seq_d[2] == 2'd3 && seq_d[4] == 2'd3) begin
					g1 = G_IN_OUT;
					n = 2'd2;
					idx_d = 3'd2;
					seq_d[3] = 2'd0;
					seq_d[4] = 2'd0;
				end
			end else if (now == 2'd0) begin
				idx_d = 3'd0;
			end

			if (idx_d == 3'd1 && now == 2'd3) begin
				if (n == 2'd0)
					g0 = G_TOO_FAST;
				else
					g1 = G_TOO_FAST;
				n = n + 2'd1;
			end

			if (idx_d == 3'd4 || (idx_d == 3'd2 && now == 2'd0)) begin
				for (int k = 0; k < SEQ_LEN; k++)
					sum = sum + {2'b00, seq_d[k]};
				case (sum)
					4'd6: begin
						if (seq_d[1] == 2'd2) begin
							gx = G_ENTERS;
							if (occ_q != 16'sh7FFF)
								occ_d = occ_q + 16'sd1;
						end else if (seq_d[1] == 2'd1) begin
							gx = G_LEAVES;
							if (occ_q != -16'sh8000)
								occ_d = occ_q - 16'sd1;
						end else begin
							gx = G_DET_ERR;
						end
					end
					4'd2, 4'd7: gx = G_TRY_ENTER;
					4'd1, 4'd5: gx = G_TRY_LEAVE;
					4'd3:       gx = G_TOO_FAST;
					default:    gx = G_NOT_FULL;
				endcase
				if (n == 2'd0)
					g0 = gx;
				else
					g1 = gx;
				n = n + 2'd1;
				idx_d = 3'd0;
				last_d = 2'd0;
				for (int k = 0; k < SEQ_LEN; k++)
					seq_d[k] = 2'd0;
			end
		end
	end

	assign evt.n = n;
	assign evt.g0 = g0;
	assign evt.g1 = g1;
	assign evt.cnt_old = occ_q;
	assign evt.cnt_new = occ_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			last_q <= '0;
			occ_q <= '0;
			for (int k = 0; k < SEQ_LEN; k++)
				seq_q[k] <= 2'd0;
		end else if (advance) begin
			idx_q <= idx_d;
			last_q <= last_d;
			occ_q <= occ_d;
			seq_q <= seq_d;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(SEQ_LEN))
		else $error("sequence index out of range");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> occ_q == $past(occ_q))
		else $error("count moved without a sample");

endmodule
`default_nettype wire

// ===== hdl/tzpg_obuf.sv =====
// Result buffer: holds the one or two event words of a sample and drains them.
`default_nettype none
module tzpg_obuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire tzpg_pkg::evt_t evt,
	output logic               can_load,
	tzpg_event_if.source       results
);
	import tzpg_pkg::*;

	logic [1:0]         cnt_q;
	logic               rd_q;
	gesture_t           g0_q, g1_q;
	logic signed [15:0] c0_q, c1_q;
	logic               pop;

	assign pop = results.valid && results.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && results.ready);

	assign results.valid = cnt_q != 2'd0;
	assign results.gesture = rd_q ? g1_q : g0_q;
	assign results.people_count = rd_q ? c1_q : c0_q;
	assign results.last_of_run = cnt_q == 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
		end else if (load) begin
			cnt_q <= evt.n;
			rd_q <= 1'b0;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			g0_q <= evt.g0;
			g1_q <= evt.g1;
			c0_q <= (evt.n == 2'd1) ? evt.cnt_new : evt.cnt_old;
			c1_q <= evt.cnt_new;
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("more than two words buffered");

	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q && cnt_q != 2'd0 |-> cnt_q == 2'd1)
		else $error("second word not marked last");

endmodule
`default_nettype wire

// ===== hdl/two_zone_passage_gesture_classifier_unit.sv =====
// Top level: two-zone passage gesture classifier with occupancy count.
//
//  channel    dir  word
//  samples    in   read_ok, front_dist_mm, back_dist_mm
//  results    out  gesture, people_count, last_of_run
//  cfg        in   cfg_we / cfg_wdata -> threshold_mm
//
// A sample is registered in the input stage, classified there and its 0, 1 or 2 event
// words are loaded into the result buffer. One sample per cycle while each yields
// at most one word and results are taken; a two-word sample holds the input stage
// while the buffer drains its first word.
// Reset clears the sequence, the count and sets threshold_mm to 800.
// A stalled result channel stalls the input stage, then samples.ready drops.
`default_nettype none
module two_zone_passage_gesture_classifier_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tzpg_sample_if.sink      samples,
	tzpg_event_if.source     results,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import tzpg_pkg::*;

	logic        vld_s1;
	logic        read_ok_s1;
	logic [15:0] front_s1, back_s1;
	logic [15:0] thr_q;
	logic        can_load;
	logic        advance;
	logic        in_fire;
	evt_t        evt;

	assign advance = vld_s1 && can_load;
	assign samples.ready = !vld_s1 || advance;
	assign in_fire = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			thr_q <= THRESH_RESET;
		end else begin
			if (in_fire)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (cfg_we)
				thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			read_ok_s1 <= samples.read_ok;
			front_s1 <= samples.front_dist_mm;
			back_s1 <= samples.back_dist_mm;
		end
	end

	tzpg_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.read_ok       (read_ok_s1),
		.front_dist_mm (front_s1),
		.back_dist_mm  (back_s1),
		.threshold_mm  (thr_q),
		.evt           (evt)
	);

	tzpg_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && evt.n != 2'd0),
		.evt      (evt),
		.can_load (can_load),
		.results  (results)
	);

endmodule
`default_nettype wire
